// ===== hw/rtl/jqd_pkg.sv =====
`timescale 1ns / 1ps

package jqd_pkg;

    localparam int HEADER_BYTES     = 12;
    localparam int TYPE_TABLE_SIZE  = 35;
    localparam int RES_FIFO_DEPTH   = 4;
    localparam int CFG_INDEX_W      = 8;
    localparam int CFG_DATA_W       = 32;

    localparam logic [31:0] MAX_BODY_RESET   = 32'd4194304;
    localparam logic [7:0]  MAX_HANDLE_RESET = 8'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_HANDLE = 8'd1;

    localparam logic [1:0] EV_BYTE    = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_INVALID = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_MAGIC      = 3'd1;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ERR_MISSING    = 3'd3;
    localparam logic [2:0] ERR_HANDLE_LEN = 3'd4;

    localparam logic [7:0] MAGIC_NUL = 8'h00;
    localparam logic [7:0] MAGIC_R   = 8'h52;
    localparam logic [7:0] MAGIC_E   = 8'h45;
    localparam logic [7:0] MAGIC_Q   = 8'h51;
    localparam logic [7:0] MAGIC_S   = 8'h53;

    typedef struct packed {
        logic [1:0]  event_res;
        logic        is_response;
        logic [31:0] frame_type;
        logic [2:0]  arg_index;
        logic [7:0]  out_byte;
        logic [2:0]  arg_count;
        logic [2:0]  error_code;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] num;
        res_t       res0;
        res_t       res1;
    } res_bundle_t;

    typedef struct packed {
        logic       unknown;
        logic [2:0] cnt;
    } arg_info_t;

    function automatic arg_info_t type_args(input logic [31:0] t);
        arg_info_t info;
        info = '{unknown: 1'b1, cnt: 3'd0};
        if (t < 32'(TYPE_TABLE_SIZE))
        begin
            unique case (t[5:0]) inside
                6'd3, 6'd4, 6'd6, 6'd9, 6'd10, 6'd24, 6'd30:
                    info = '{unknown: 1'b0, cnt: 3'd0};
                6'd1, 6'd2, 6'd8, 6'd14, 6'd15, 6'd16, 6'd17, 6'd22, 6'd26, 6'd27:
                    info = '{unknown: 1'b0, cnt: 3'd1};
                6'd13, 6'd19, 6'd23, 6'd25, 6'd28, 6'd29:
                    info = '{unknown: 1'b0, cnt: 3'd2};
                6'd7, 6'd11, 6'd12, 6'd18, 6'd21, 6'd32, 6'd33, 6'd34:
                    info = '{unknown: 1'b0, cnt: 3'd3};
                6'd31:
                    info = '{unknown: 1'b0, cnt: 3'd4};
                6'd20:
                    info = '{unknown: 1'b0, cnt: 3'd5};
                default:
                    info = '{unknown: 1'b1, cnt: 3'd0};
            endcase
        end
        return info;
    endfunction

    function automatic logic type_has_handle(input logic [31:0] t);
        logic h;
        h = 1'b0;
        if (t < 32'(TYPE_TABLE_SIZE))
        begin
            unique case (t[5:0]) inside
                6'd8, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd20, 6'd25, 6'd28, 6'd29, 6'd31:
                    h = 1'b1;
                default:
                    h = 1'b0;
            endcase
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/job_queue_packet_deframer_unit.sv =====
`timescale 1ns / 1ps
// channel   signals                                      word
// in        in_valid, in_ready, data_byte                one stream byte
// out       out_valid, out_ready, event_res .. last      one result
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data    one register write
//
// One byte is accepted per cycle while in_ready is high; its results enter the result
// queue at the accepting edge and are offered one per cycle while out_ready is high. A
// header byte gives a result only on a bad magic byte or at the last header byte (size
// error or empty body); a body byte gives at most one, the last body byte up to two.
// in_ready follows the queue fill alone: it drops only with fewer than two free entries.
// cfg_ready is always high. Reset is asynchronous and needs no clearing pass; after an
// invalid result no further results appear until reset.

module job_queue_packet_deframer_unit
    import jqd_pkg::*;
#(
    parameter int FIFO_DEPTH = RES_FIFO_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             event_res,
    output logic                   is_response,
    output logic [31:0]            frame_type,
    output logic [2:0]             arg_index,
    output logic [7:0]             out_byte,
    output logic [2:0]             arg_count,
    output logic [2:0]             error_code,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    res_bundle_t bundle;
    res_t        head;
    logic        space_ok;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = space_ok;
    assign accept    = in_valid && in_ready;

    jqd_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bundle    (bundle)
    );

    jqd_res_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bundle),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign event_res   = head.event_res;
    assign is_response = head.is_response;
    assign frame_type  = head.frame_type;
    assign arg_index   = head.arg_index;
    assign out_byte    = head.out_byte;
    assign arg_count   = head.arg_count;
    assign error_code  = head.error_code;
    assign last        = head.last;

endmodule

// ===== hw/rtl/jqd_decoder.sv =====
`timescale 1ns / 1ps

module jqd_decoder
    import jqd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output res_bundle_t            bundle
);

    logic [31:0] max_body_reg;
    logic [7:0]  max_handle_reg;

    logic [3:0]  hp_reg,   hp_next;
    logic        resp_reg, resp_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] blen_reg, blen_next;
    logic [31:0] bpos_reg, bpos_next;
    logic [2:0]  carg_reg, carg_next;
    logic [8:0]  fal_reg,  fal_next;
    logic        lock_reg, lock_next;

    function automatic res_t finish_res(
        input logic [31:0] t,
        input logic        resp,
        input logic [31:0] blen,
        input logic [2:0]  carg,
        input logic [8:0]  fal,
        input logic [7:0]  maxh
    );
        res_t      r;
        arg_info_t info;
        r = '0;
        info = type_args(t);
        r.is_response = resp;
        r.frame_type  = t;
        if (!info.unknown && info.cnt > 3'd1 && ({1'b0, carg} + 4'd1) < {1'b0, info.cnt})
        begin
            r.event_res  = EV_INVALID;
            r.error_code = ERR_MISSING;
        end
        else if (!info.unknown && info.cnt != 3'd0 && type_has_handle(t)
                 && fal > {1'b0, maxh})
        begin
            r.event_res  = EV_INVALID;
            r.error_code = ERR_HANDLE_LEN;
        end
        else
        begin
            r.event_res = EV_DONE;
            r.arg_count = info.unknown ? {2'b00, (blen != 32'd0)} : info.cnt;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg   <= MAX_BODY_RESET;
            max_handle_reg <= MAX_HANDLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_BODY:   max_body_reg   <= cfg_data;
                REG_MAX_HANDLE: max_handle_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        logic        magic_ok;
        logic        emit;
        logic        want_fin;
        res_t        byte_res;
        res_t        fin;
        arg_info_t   info;

        hp_next   = hp_reg;
        resp_next = resp_reg;
        type_next = type_reg;
        blen_next = blen_reg;
        bpos_next = bpos_reg;
        carg_next = carg_reg;
        fal_next  = fal_reg;
        lock_next = lock_reg;
        bundle    = '0;
        magic_ok  = 1'b1;
        emit      = 1'b0;
        want_fin  = 1'b0;
        byte_res  = '0;
        info      = type_args(type_reg);

        if (accept && !lock_reg)
        begin
            if (hp_reg < 4'(HEADER_BYTES))
            begin
                if (hp_reg[3:2] == 2'b00)
                begin
                    case (hp_reg[1:0])
                        2'd0:    magic_ok = (data_byte == MAGIC_NUL);
                        2'd1:    magic_ok = (data_byte == MAGIC_R);
                        2'd2:    magic_ok = (data_byte == MAGIC_E);
                        default: magic_ok = (data_byte == MAGIC_Q) || (data_byte == MAGIC_S);
                    endcase
                    if (hp_reg[1:0] == 2'd3)
                        resp_next = (data_byte == MAGIC_S);
                end
                else if (hp_reg[3:2] == 2'b01)
                    type_next = {type_reg[23:0], data_byte};
                else
                    blen_next = {blen_reg[23:0], data_byte};

                if (!magic_ok)
                begin
                    bundle.num             = 2'd1;
                    bundle.res0.event_res  = EV_INVALID;
                    bundle.res0.error_code = ERR_MAGIC;
                    bundle.res0.last       = 1'b1;
                    lock_next              = 1'b1;
                    resp_next              = resp_reg;
                end
                else
                begin
                    hp_next = hp_reg + 4'd1;
                    if (hp_reg == 4'(HEADER_BYTES - 1))
                    begin
                        if (blen_next > max_body_reg)
                        begin
                            bundle.num              = 2'd1;
                            bundle.res0.event_res   = EV_INVALID;
                            bundle.res0.error_code  = ERR_TOO_LARGE;
                            bundle.res0.is_response = resp_reg;
                            bundle.res0.frame_type  = type_reg;
                            bundle.res0.last        = 1'b1;
                            lock_next               = 1'b1;
                        end
                        else if (blen_next == 32'd0)
                            want_fin = 1'b1;
                    end
                end
            end
            else
            begin
                byte_res.event_res   = EV_BYTE;
                byte_res.is_response = resp_reg;
                byte_res.frame_type  = type_reg;
                byte_res.out_byte    = data_byte;
                if (info.unknown)
                    emit = 1'b1;
                else if (info.cnt != 3'd0)
                begin
                    if (data_byte == 8'd0 && ({1'b0, carg_reg} + 4'd1) < {1'b0, info.cnt})
                        carg_next = carg_reg + 3'd1;
                    else
                    begin
                        emit               = 1'b1;
                        byte_res.arg_index = carg_reg;
                        if (carg_reg == 3'd0 && fal_reg != 9'h1FF)
                            fal_next = fal_reg + 9'd1;
                    end
                end
                bpos_next = bpos_reg + 32'd1;
                want_fin  = (bpos_next == blen_reg);
            end
        end

        fin = finish_res(type_next, resp_next, blen_next, carg_next, fal_next, max_handle_reg);
        fin.last = 1'b1;

        if (want_fin)
        begin
            if (emit)
            begin
                bundle.num  = 2'd2;
                bundle.res0 = byte_res;
                bundle.res1 = fin;
            end
            else
            begin
                bundle.num  = 2'd1;
                bundle.res0 = fin;
            end
            if (fin.event_res == EV_INVALID)
                lock_next = 1'b1;
            else
            begin
                hp_next   = 4'd0;
                type_next = 32'd0;
                blen_next = 32'd0;
                bpos_next = 32'd0;
                carg_next = 3'd0;
                fal_next  = 9'd0;
            end
        end
        else if (emit)
        begin
            bundle.num       = 2'd1;
            bundle.res0      = byte_res;
            bundle.res0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg   <= '0;
            resp_reg <= 1'b0;
            type_reg <= '0;
            blen_reg <= '0;
            bpos_reg <= '0;
            carg_reg <= '0;
            fal_reg  <= '0;
            lock_reg <= 1'b0;
        end
        else
        begin
            hp_reg   <= hp_next;
            resp_reg <= resp_next;
            type_reg <= type_next;
            blen_reg <= blen_next;
            bpos_reg <= bpos_next;
            carg_reg <= carg_next;
            fal_reg  <= fal_next;
            lock_reg <= lock_next;
        end
    end

    a_lock_silent: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> bundle.num == 2'd0)
        else $error("results produced while locked");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.num == 2'd2 |-> bundle.res1.last && !bundle.res0.last
                               && bundle.res0.event_res == EV_BYTE)
        else $error("bad ordering of a result pair");

    a_lock_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(lock_reg) |-> $past(bundle.num != 2'd0))
        else $error("lock set without an invalid result");

endmodule

// ===== hw/rtl/jqd_res_fifo.sv =====
`timescale 1ns / 1ps

module jqd_res_fifo
    import jqd_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  res_bundle_t push,
    output logic        space_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [PW-1:0] wr_ptr_b;
    logic          pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign space_ok  = (count_reg <= CW'(DEPTH - 2));
    assign head      = mem[rd_ptr_reg];
    assign wr_ptr_b  = wrap_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.num == 2'd1)
            wr_ptr_next = wr_ptr_b;
        else if (push.num == 2'd2)
            wr_ptr_next = wrap_inc(wr_ptr_b);
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.num) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            mem[wr_ptr_reg] <= push.res0;
        if (push.num == 2'd2)
            mem[wr_ptr_b] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.num != 2'd0 |-> space_ok)
        else $error("push without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(head))
        else $error("waiting word changed");

endmodule

// ===== bench/job_queue_packet_deframer_unit_tb.sv =====
`timescale 1ns / 1ps

module job_queue_packet_deframer_unit_tb;

    import jqd_pkg::*;

    localparam int          SETTLE_CYCLES  = 8;
    localparam logic [7:0]  REG_UNUSED     = 8'hFF;
    localparam logic [7:0]  NUL            = 8'h00;
    localparam logic [31:0] TYPE_NO_ARGS   = 32'd3;
    localparam logic [31:0] TYPE_FIVE_ARGS = 32'd20;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             data_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             event_res;
    logic                   is_response;
    logic [31:0]            frame_type;
    logic [2:0]             arg_index;
    logic [7:0]             out_byte;
    logic [2:0]             arg_count;
    logic [2:0]             error_code;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    job_queue_packet_deframer_unit u_dut (.*);

    always #5 clk = ~clk;

    // deframer state as the block should hold it
    logic [31:0] lim_body      = MAX_BODY_RESET;
    logic [7:0]  lim_handle    = MAX_HANDLE_RESET;
    logic [3:0]  hdr_pos       = '0;
    logic        pkt_is_res    = 1'b0;
    logic [31:0] pkt_type      = '0;
    logic [31:0] pkt_len       = '0;
    logic [31:0] body_count    = '0;
    logic [2:0]  arg_sel       = '0;
    logic [8:0]  handle_len    = '0;
    logic        stream_locked = 1'b0;

    res_t        pending_results[$];
    logic [7:0]  body_bytes[$];
    int          errors     = 0;
    int          bytes_sent = 0;
    int          stall_left = 0;
    bit          quiet      = 1'b0;

    function automatic int args_of(input logic [31:0] t);
        if (t >= TYPE_TABLE_SIZE)
            return -1;
        case (t[5:0])
            6'd3, 6'd4, 6'd6, 6'd9, 6'd10, 6'd24, 6'd30:
                return 0;
            6'd1, 6'd2, 6'd8, 6'd14, 6'd15, 6'd16, 6'd17, 6'd22, 6'd26, 6'd27:
                return 1;
            6'd13, 6'd19, 6'd23, 6'd25, 6'd28, 6'd29:
                return 2;
            6'd7, 6'd11, 6'd12, 6'd18, 6'd21, 6'd32, 6'd33, 6'd34:
                return 3;
            6'd31:
                return 4;
            6'd20:
                return 5;
            default:
                return -1;
        endcase
    endfunction

    function automatic bit has_handle(input logic [31:0] t);
        if (t >= TYPE_TABLE_SIZE)
            return 1'b0;
        case (t[5:0])
            6'd8, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd20, 6'd25, 6'd28, 6'd29, 6'd31:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic res_t make_res(input logic [1:0] ev, input logic resp,
                                      input logic [31:0] typ, input logic [2:0] idx,
                                      input logic [7:0] b, input logic [2:0] cnt,
                                      input logic [2:0] err);
        res_t r;
        r.event_res   = ev;
        r.is_response = resp;
        r.frame_type  = typ;
        r.arg_index   = idx;
        r.out_byte    = b;
        r.arg_count   = cnt;
        r.error_code  = err;
        r.last        = 1'b0;
        return r;
    endfunction

    // end of body: done, which restarts the header, or invalid, which locks the stream
    function automatic res_t close_packet();
        int   cnt;
        res_t r;
        cnt = args_of(pkt_type);
        if (cnt > 1 && int'(arg_sel) + 1 < cnt)
        begin
            stream_locked = 1'b1;
            return make_res(EV_INVALID, pkt_is_res, pkt_type, 3'd0, 8'd0, 3'd0, ERR_MISSING);
        end
        if (cnt > 0 && has_handle(pkt_type) && handle_len > {1'b0, lim_handle})
        begin
            stream_locked = 1'b1;
            return make_res(EV_INVALID, pkt_is_res, pkt_type, 3'd0, 8'd0, 3'd0,
                            ERR_HANDLE_LEN);
        end
        r = make_res(EV_DONE, pkt_is_res, pkt_type, 3'd0, 8'd0,
                     cnt < 0 ? ((pkt_len != 0) ? 3'd1 : 3'd0) : 3'(cnt), ERR_NONE);
        hdr_pos    = '0;
        pkt_type   = '0;
        pkt_len    = '0;
        body_count = '0;
        arg_sel    = '0;
        handle_len = '0;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        res_t r[2];
        int   n;
        int   cnt;
        bit   ok;
        n = 0;
        if (stream_locked)
            return;
        if (hdr_pos < HEADER_BYTES)
        begin
            if (hdr_pos < 4)
            begin
                case (hdr_pos)
                    4'd0:    ok = (b == MAGIC_NUL);
                    4'd1:    ok = (b == MAGIC_R);
                    4'd2:    ok = (b == MAGIC_E);
                    default: ok = (b == MAGIC_Q || b == MAGIC_S);
                endcase
                if (!ok)
                begin
                    r[0] = make_res(EV_INVALID, 1'b0, 32'd0, 3'd0, 8'd0, 3'd0, ERR_MAGIC);
                    r[0].last = 1'b1;
                    pending_results = {pending_results, r[0]};
                    stream_locked = 1'b1;
                    return;
                end
                if (hdr_pos == 4'd3)
                    pkt_is_res = (b == MAGIC_S);
            end
            else if (hdr_pos < 8)
                pkt_type = {pkt_type[23:0], b};
            else
                pkt_len = {pkt_len[23:0], b};
            hdr_pos = hdr_pos + 4'd1;
            if (hdr_pos == HEADER_BYTES)
            begin
                if (pkt_len > lim_body)
                begin
                    r[0] = make_res(EV_INVALID, pkt_is_res, pkt_type, 3'd0, 8'd0, 3'd0,
                                    ERR_TOO_LARGE);
                    stream_locked = 1'b1;
                    n = 1;
                end
                else if (pkt_len == 0)
                begin
                    r[0] = close_packet();
                    n = 1;
                end
            end
        end
        else
        begin
            cnt = args_of(pkt_type);
            if (cnt < 0)
            begin
                r[n] = make_res(EV_BYTE, pkt_is_res, pkt_type, 3'd0, b, 3'd0, ERR_NONE);
                n = n + 1;
            end
            else if (cnt > 0)
            begin
                if (b == NUL && int'(arg_sel) + 1 < cnt)
                    arg_sel = arg_sel + 3'd1;
                else
                begin
                    r[n] = make_res(EV_BYTE, pkt_is_res, pkt_type, arg_sel, b, 3'd0, ERR_NONE);
                    n = n + 1;
                    if (arg_sel == 0 && handle_len < 9'd511)
                        handle_len = handle_len + 9'd1;
                end
            end
            body_count = body_count + 32'd1;
            if (body_count == pkt_len)
            begin
                r[n] = close_packet();
                n = n + 1;
            end
        end
        if (n > 0)
            r[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_results = {pending_results, r[i]};
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
        errors++;
    endtask

    task automatic compare_result(input res_t want, input res_t got);
        if (got.event_res !== want.event_res)
            report_field("event_res", want.event_res, got.event_res);
        if (got.is_response !== want.is_response)
            report_field("is_response", want.is_response, got.is_response);
        if (got.frame_type !== want.frame_type)
            report_field("frame_type", want.frame_type, got.frame_type);
        if (got.arg_index !== want.arg_index)
            report_field("arg_index", want.arg_index, got.arg_index);
        if (got.out_byte !== want.out_byte)
            report_field("out_byte", want.out_byte, got.out_byte);
        if (got.arg_count !== want.arg_count)
            report_field("arg_count", want.arg_count, got.arg_count);
        if (got.error_code !== want.error_code)
            report_field("error_code", want.error_code, got.error_code);
        if (got.last !== want.last)
            report_field("last", want.last, got.last);
    endtask

    always @(posedge clk)
    begin : check_proc
        res_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_BODY)
                    lim_body = cfg_data;
                else if (cfg_index == REG_MAX_HANDLE)
                    lim_handle = cfg_data[7:0];
            end
            if (in_valid && in_ready)
                deframe_byte(data_byte);
            if (out_valid && out_ready)
            begin
                got = {event_res, is_response, frame_type, arg_index, out_byte,
                       arg_count, error_code, last};
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected word expected none actual %0h", $time, got);
                    errors++;
                end
                else
                    compare_result(pending_results.pop_front(), got);
            end
        end
    end

    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] magic_byte(input int pos);
        case (pos)
            0:       return MAGIC_NUL;
            1:       return MAGIC_R;
            2:       return MAGIC_E;
            default: return MAGIC_Q;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return ($urandom_range(0, 3) == 0) ? NUL : 8'($urandom);
    endfunction

    task automatic send_header(input logic resp, input logic [31:0] typ,
                               input logic [31:0] len);
        for (int i = 0; i < 3; i++)
            send_byte(magic_byte(i));
        send_byte(resp ? MAGIC_S : MAGIC_Q);
        for (int i = 3; i >= 0; i--)
            send_byte(typ[i*8 +: 8]);
        for (int i = 3; i >= 0; i--)
            send_byte(len[i*8 +: 8]);
    endtask

    task automatic send_packet(input logic resp, input logic [31:0] typ);
        send_header(resp, typ, 32'(body_bytes.size()));
        foreach (body_bytes[i])
            send_byte(body_bytes[i]);
    endtask

    // body that passes every check under the current limits
    task automatic make_body(input logic [31:0] typ, input int max_len, input int arg_max);
        int cnt;
        int budget;
        int cap;
        int len;
        body_bytes.delete();
        cnt = args_of(typ);
        if (cnt <= 0)
        begin
            len = $urandom_range(0, max_len < arg_max ? max_len : arg_max);
            repeat (len) body_bytes = {body_bytes, rand_byte()};
        end
        else
        begin
            budget = max_len - (cnt - 1);
            for (int i = 0; i < cnt; i++)
            begin
                cap = arg_max < budget ? arg_max : budget;
                if (i == 0 && has_handle(typ) && int'(lim_handle) < cap)
                    cap = int'(lim_handle);
                len = $urandom_range(0, cap);
                budget -= len;
                if (i > 0)
                    body_bytes = {body_bytes, NUL};
                repeat (len)
                    body_bytes = {body_bytes,
                                  (i == cnt - 1) ? rand_byte() : 8'($urandom_range(1, 255))};
            end
        end
    endtask

    function automatic logic [31:0] pick_type(input int max_len);
        logic [31:0] t;
        int          k;
        k = $urandom_range(0, 9);
        if (k < 8)
            t = $urandom_range(0, TYPE_TABLE_SIZE - 1);
        else if (k == 8)
            t = $urandom_range(TYPE_TABLE_SIZE, 255);
        else
            t = $urandom;
        if (args_of(t) - 1 > max_len)
            t = TYPE_NO_ARGS;
        return t;
    endfunction

    task automatic run_random(input int budget, input int long_pct);
        int          start;
        int          max_len;
        int          arg_max;
        logic [31:0] t;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            max_len = (lim_body < 32'd24) ? int'(lim_body) : 24;
            arg_max = 4;
            if ($urandom_range(0, 99) < long_pct && lim_body >= 32'd300)
            begin
                max_len = 300;
                arg_max = 255;
            end
            t = pick_type(max_len);
            make_body(t, max_len, arg_max);
            send_packet(1'($urandom_range(0, 1)), t);
        end
    endtask

    task automatic test_directed();
        body_bytes.delete();
        send_packet(1'b0, TYPE_NO_ARGS);
        body_bytes = '{8'hFF, NUL, NUL, NUL, NUL, NUL};
        send_packet(1'b1, TYPE_FIVE_ARGS);
    endtask

    task automatic test_default_limits();
        run_random(300, 0);
    endtask

    task automatic test_zero_limits();
        wait_idle();
        write_reg(REG_MAX_BODY, 32'd0);
        write_reg(REG_MAX_HANDLE, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        run_random(150, 0);
    endtask

    task automatic test_wide_limits();
        wait_idle();
        write_reg(REG_MAX_BODY, 32'hFFFF_FFFF);
        write_reg(REG_MAX_HANDLE, 32'd255);
        run_random(300, 8);
    endtask

    task automatic test_random_limits();
        repeat (3)
        begin
            wait_idle();
            write_reg(REG_MAX_BODY, $urandom_range(0, 30));
            write_reg(REG_MAX_HANDLE, $urandom_range(0, 6));
            run_random(100, 0);
        end
    endtask

    task automatic test_back_to_back();
        wait_idle();
        quiet = 1'b1;
        write_reg(REG_MAX_BODY, MAX_BODY_RESET);
        write_reg(REG_MAX_HANDLE, 32'(MAX_HANDLE_RESET));
        run_random(150, 0);
    endtask

    // one invalid packet locks the block for the rest of the run
    task automatic test_error_lock();
        int          kind;
        int          pos;
        int          cnt;
        logic [7:0]  b;
        logic [31:0] t;
        logic [31:0] lim;
        kind = $urandom_range(0, 3);
        case (kind)
            0:
            begin
                pos = $urandom_range(0, 3);
                for (int i = 0; i < pos; i++)
                    send_byte(magic_byte(i));
                b = 8'($urandom);
                while ((pos < 3 && b == magic_byte(pos)) ||
                       (pos == 3 && (b == MAGIC_Q || b == MAGIC_S)))
                    b = 8'($urandom);
                send_byte(b);
            end
            1:
            begin
                wait_idle();
                lim = $urandom;
                if (lim == 32'hFFFF_FFFF)
                    lim = 32'hFFFF_FFFE;
                write_reg(REG_MAX_BODY, lim);
                send_header(1'($urandom_range(0, 1)), $urandom,
                            lim + 32'd1 + ($urandom % (~lim)));
            end
            2:
            begin
                t = $urandom_range(0, TYPE_TABLE_SIZE - 1);
                while (args_of(t) < 2)
                    t = $urandom_range(0, TYPE_TABLE_SIZE - 1);
                cnt = args_of(t);
                body_bytes.delete();
                repeat ($urandom_range(0, cnt - 2)) body_bytes = {body_bytes, NUL};
                repeat ($urandom_range(0, 5))
                    body_bytes = {body_bytes, 8'($urandom_range(1, 255))};
                send_packet(1'($urandom_range(0, 1)), t);
            end
            default:
            begin
                wait_idle();
                write_reg(REG_MAX_HANDLE, $urandom_range(0, 8));
                t = $urandom_range(0, TYPE_TABLE_SIZE - 1);
                while (!has_handle(t))
                    t = $urandom_range(0, TYPE_TABLE_SIZE - 1);
                body_bytes.delete();
                repeat (int'(lim_handle) + 1)
                    body_bytes = {body_bytes, 8'($urandom_range(1, 255))};
                repeat (args_of(t) - 1) body_bytes = {body_bytes, NUL};
                send_packet(1'($urandom_range(0, 1)), t);
            end
        endcase
        repeat (16) send_byte(8'($urandom));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = '0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_default_limits();
        test_zero_limits();
        test_wide_limits();
        test_random_limits();
        test_back_to_back();
        test_error_lock();
        wait_idle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
